/* rtl/madr_pkg.sv */
// shared constants and types for the moving average deadband reporter
`default_nettype none

package madr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MEAN_W   = 16;
  localparam int THRESH_W = 16;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd16;

  // result queue sizing, also bounds the number of samples in flight
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = 3;
  localparam int OUT_CNT_W = 4;

  // outcome of one candidate sample leaving the compare stage
  typedef struct packed {
    logic push;
    logic drop;
  } madr_evt_t;

endpackage

`default_nettype wire

/* rtl/madr_window.sv */
// ring of window samples, fill control and running sum
`default_nettype none

module madr_window #(
  parameter int WINDOW = 25
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         acc_i,
  input  wire logic [madr_pkg::SAMPLE_W-1:0]                sample_i,
  output logic                                              sum_vld_o,
  output logic [madr_pkg::SAMPLE_W+$clog2(WINDOW)-1:0]      sum_o,
  output logic                                              fill_drop_o
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = madr_pkg::SAMPLE_W + $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
  localparam logic [FILL_W-1:0] FULL_CNT  = FILL_W'(WINDOW);

  logic [madr_pkg::SAMPLE_W-1:0] ring [WINDOW];

  logic [SLOT_W-1:0]             slot_r;
  logic [FILL_W-1:0]             fill_r;
  logic                          s1_vld_r;
  logic                          full_r;
  logic [madr_pkg::SAMPLE_W-1:0] old_r;
  logic [madr_pkg::SAMPLE_W-1:0] new_r;
  logic [SUM_W-1:0]              sum_r;
  logic [SUM_W-1:0]              sum_nxt;
  logic                          s2_vld_r;

  // old entry is read before the new sample overwrites it
  always_ff @(posedge clk) begin
    if (acc_i) begin
      ring[slot_r] <= sample_i;
      old_r        <= ring[slot_r];
      new_r        <= sample_i;
      full_r       <= (fill_r == FULL_CNT);
    end
  end

  always_comb begin
    sum_nxt = sum_r + SUM_W'(new_r) - (full_r ? SUM_W'(old_r) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      fill_r   <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      sum_r    <= '0;
    end else begin
      s1_vld_r <= acc_i;
      s2_vld_r <= s1_vld_r && full_r;
      if (acc_i) begin
        slot_r <= (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
        if (fill_r != FULL_CNT) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (s1_vld_r) begin
        sum_r <= sum_nxt;
      end
    end
  end

  assign sum_vld_o   = s2_vld_r;
  assign sum_o       = sum_r;
  assign fill_drop_o = s1_vld_r && !full_r;

endmodule

`default_nettype wire

/* rtl/madr_mean.sv */
// reciprocal divide of the running sum and deadband compare
`default_nettype none

module madr_mean #(
  parameter int WINDOW = 25
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     sum_vld_i,
  input  wire logic [madr_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] sum_i,
  input  wire logic [madr_pkg::THRESH_W-1:0]            thresh_i,
  output madr_pkg::madr_evt_t                           evt_o,
  output logic [madr_pkg::MEAN_W-1:0]                   mean_o
);

  localparam int SUM_W  = madr_pkg::SAMPLE_W + $clog2(WINDOW);
  localparam int SHIFT  = SUM_W + $clog2(WINDOW);
  localparam int MULT_W = SUM_W + 1;
  localparam int PROD_W = SUM_W + MULT_W;
  // ceil(2^SHIFT / WINDOW) gives an exact floor quotient for any sum below 2^SUM_W
  localparam longint unsigned MULT_L =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_L);

  logic [PROD_W-1:0]             prod_r;
  logic                          s3_vld_r;
  logic [madr_pkg::MEAN_W-1:0]   last_r;
  logic [madr_pkg::MEAN_W-1:0]   mean;
  logic [madr_pkg::MEAN_W-1:0]   diff;
  logic                          report;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(sum_i) * PROD_W'(MULT);
  end

  always_comb begin
    mean   = prod_r[SHIFT +: madr_pkg::MEAN_W];
    diff   = (mean >= last_r) ? mean - last_r : last_r - mean;
    report = s3_vld_r && (diff >= thresh_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      last_r   <= '0;
    end else begin
      s3_vld_r <= sum_vld_i;
      if (report) begin
        last_r <= mean;
      end
    end
  end

  assign evt_o.push = report;
  assign evt_o.drop = s3_vld_r && !report;
  assign mean_o     = mean;

endmodule

`default_nettype wire

/* rtl/madr_out_fifo.sv */
// small result queue that drives the output channel
`default_nettype none

module madr_out_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push_i,
  input  wire logic [madr_pkg::MEAN_W-1:0]   data_i,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [madr_pkg::MEAN_W-1:0]        out_tdata,
  output logic                               pop_o
);

  logic [madr_pkg::MEAN_W-1:0]  queue [madr_pkg::OUT_DEPTH];
  logic [madr_pkg::OUT_PTR_W-1:0] wptr_r;
  logic [madr_pkg::OUT_PTR_W-1:0] rptr_r;
  logic [madr_pkg::OUT_CNT_W-1:0] cnt_r;
  logic                           pop;

  assign pop = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (push_i) begin
      queue[wptr_r] <= data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push_i) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + madr_pkg::OUT_CNT_W'(push_i) - madr_pkg::OUT_CNT_W'(pop);
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = queue[rptr_r];
  assign pop_o      = pop;

endmodule

`default_nettype wire

/* rtl/moving_average_deadband_reporter.sv */
// a reporting sample passes ring read, sum, product and queue registers
// one sample per cycle while ready, set by the single-port ring read and write
// in_tready drops only while 8 samples are in flight or queued as results
// reset (rst_n low, synchronous) empties the window and queue, clears the sum
// and last reported mean, and loads a threshold of 16; ring contents are kept
`default_nettype none

module moving_average_deadband_reporter #(
  parameter int WINDOW = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] sample_value
  input  wire logic [0:0]  in_tuser,   // [0] sample_valid
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] reported_mean
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data // report_threshold
);

  localparam int SUM_W = madr_pkg::SAMPLE_W + $clog2(WINDOW);
  localparam int CNT_W = madr_pkg::OUT_CNT_W;

  logic [madr_pkg::THRESH_W-1:0] thresh_r;
  logic [CNT_W-1:0]              credit_r;
  logic [CNT_W-1:0]              credit_nxt;
  logic                          acc;
  logic                          sum_vld;
  logic [SUM_W-1:0]              sum;
  logic                          fill_drop;
  madr_pkg::madr_evt_t           evt;
  logic [madr_pkg::MEAN_W-1:0]   mean;
  logic                          pop;

  assign in_tready = (credit_r < CNT_W'(madr_pkg::OUT_DEPTH));
  // samples flagged invalid change nothing
  assign acc = in_tvalid && in_tready && in_tuser[0];

  always_comb begin
    credit_nxt = credit_r + CNT_W'(acc) - CNT_W'(fill_drop) - CNT_W'(evt.drop)
                 - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= madr_pkg::THRESH_RESET;
      credit_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      credit_r <= credit_nxt;
    end
  end

  madr_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc_i       (acc),
    .sample_i    (in_tdata),
    .sum_vld_o   (sum_vld),
    .sum_o       (sum),
    .fill_drop_o (fill_drop)
  );

  madr_mean #(
    .WINDOW (WINDOW)
  ) u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_vld_i (sum_vld),
    .sum_i     (sum),
    .thresh_i  (thresh_r),
    .evt_o     (evt),
    .mean_o    (mean)
  );

  madr_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (evt.push),
    .data_i     (mean),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .pop_o      (pop)
  );

endmodule

`default_nettype wire

/* rtl/madr_checker.sv */
// port-level checks for the moving average deadband reporter
`default_nettype none

module madr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [0:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending right after reset");

  // reset returns all credits
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready right after reset");

  // a new result can only follow a valid sample transaction
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tuser[0], 4))
    else $error("result without a matching valid sample transaction");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind moving_average_deadband_reporter madr_checker u_madr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
